FILE: src/ssm_pkg.sv
package ssm_pkg;

    localparam int DUTY_W   = 16;
    localparam int SAMPLE_W = 12;
    localparam int ANGLE_W  = 7;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_STARTING = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_STOPPING = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DUTY  = 3'd0,
        REG_MIN_DUTY  = 3'd1,
        REG_DUTY_STEP = 3'd2,
        REG_NEAR_THR  = 3'd3,
        REG_FAR_THR   = 3'd4
    } t_reg_idx;

    localparam logic [DUTY_W-1:0]   MAX_DUTY_RST  = 16'd65535;
    localparam logic [DUTY_W-1:0]   MIN_DUTY_RST  = 16'd0;
    localparam logic [DUTY_W-1:0]   DUTY_STEP_RST = 16'd1000;
    localparam logic [SAMPLE_W-1:0] NEAR_THR_RST  = 12'd2000;
    localparam logic [SAMPLE_W-1:0] FAR_THR_RST   = 12'd1000;
    localparam logic [ANGLE_W-1:0]  SERVO_ON_DEG  = 7'd90;
    localparam logic [ANGLE_W-1:0]  SERVO_OFF_DEG = 7'd0;

    typedef struct packed {
        logic [DUTY_W-1:0]   max_duty;
        logic [DUTY_W-1:0]   min_duty;
        logic [DUTY_W-1:0]   duty_step;
        logic [SAMPLE_W-1:0] near_thr;
        logic [SAMPLE_W-1:0] far_thr;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              written;
        t_mode             mode;
        logic              present;
    } t_result;

endpackage

FILE: src/ssm_cfg.sv
module ssm_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [ssm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssm_pkg::DUTY_W-1:0]   i_cfg_data,
    output ssm_pkg::t_cfg                o_cfg
);
    import ssm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_duty  <= MAX_DUTY_RST;
            r_cfg.min_duty  <= MIN_DUTY_RST;
            r_cfg.duty_step <= DUTY_STEP_RST;
            r_cfg.near_thr  <= NEAR_THR_RST;
            r_cfg.far_thr   <= FAR_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAX_DUTY:  r_cfg.max_duty  <= i_cfg_data;
                REG_MIN_DUTY:  r_cfg.min_duty  <= i_cfg_data;
                REG_DUTY_STEP: r_cfg.duty_step <= i_cfg_data;
                REG_NEAR_THR:  r_cfg.near_thr  <= i_cfg_data[SAMPLE_W-1:0];
                REG_FAR_THR:   r_cfg.far_thr   <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/ssm_tick.sv
module ssm_tick (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [ssm_pkg::SAMPLE_W-1:0] i_sample,
    input  ssm_pkg::t_cfg               i_cfg,
    output ssm_pkg::t_result            o_res
);
    import ssm_pkg::*;

    t_mode             r_mode;
    t_mode             n_mode;
    logic [DUTY_W-1:0] r_duty;
    logic [DUTY_W-1:0] n_duty;
    logic              r_det;
    logic              n_det;
    t_mode             entry_mode;
    logic              written;
    logic [DUTY_W-1:0] gap;

    assign gap = i_cfg.max_duty - r_duty;

    always_comb begin
        entry_mode = r_mode;
        if (r_mode == MODE_IDLE && r_det) begin
            entry_mode = MODE_STARTING;
        end else if (r_mode == MODE_RUNNING && !r_det) begin
            entry_mode = MODE_STOPPING;
        end
        n_mode = entry_mode;
        unique case (entry_mode)
            MODE_STARTING: begin
                if (r_duty >= i_cfg.max_duty) n_mode = MODE_RUNNING;
            end
            MODE_STOPPING: begin
                if (r_duty <= i_cfg.min_duty) n_mode = MODE_IDLE;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_duty  = r_duty;
        written = 1'b0;
        unique case (entry_mode)
            MODE_STARTING: begin
                if (r_duty < i_cfg.max_duty) begin
                    written = 1'b1;
                    n_duty  = (gap <= i_cfg.duty_step) ? i_cfg.max_duty
                                                       : r_duty + i_cfg.duty_step;
                end
            end
            MODE_STOPPING: begin
                if (r_duty > i_cfg.min_duty) begin
                    written = 1'b1;
                    n_duty  = (r_duty < i_cfg.duty_step) ? '0 : r_duty - i_cfg.duty_step;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_det = r_det;
        if (i_sample >= i_cfg.near_thr) begin
            n_det = 1'b1;
        end else if (i_sample <= i_cfg.far_thr) begin
            n_det = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_duty <= '0;
            r_det  <= 1'b0;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_duty <= n_duty;
            r_det  <= n_det;
        end
    end

    assign o_res.duty    = n_duty;
    assign o_res.written = written;
    assign o_res.mode    = n_mode;
    assign o_res.present = n_det;

endmodule

FILE: src/soft_start_stop_motor_ramp.sv
// Channel  Valid          Stall / ready   Payload
// input    i_in_valid     o_in_stall      i_proximity_sample
// output   o_out_valid    i_out_stall     o_duty_level .. o_servo_angle
// config   i_cfg_valid    o_cfg_ready     i_cfg_index, i_cfg_data
//
// One tick per cycle unless stalled or empty, through a sample register,
// then the ramp and hysteresis update into the result register.
// Synchronous active-low reset returns idle mode, zero duty, flag clear and
// register defaults. An output stall holds the result and the sample stage
// behind it; the input stalls only when both are full.
module soft_start_stop_motor_ramp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ssm_pkg::SAMPLE_W-1:0]  i_proximity_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ssm_pkg::DUTY_W-1:0]    o_duty_level,
    output logic                          o_duty_written,
    output logic [1:0]                    o_motor_mode,
    output logic                          o_object_present,
    output logic [ssm_pkg::ANGLE_W-1:0]   o_servo_angle,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssm_pkg::DUTY_W-1:0]    i_cfg_data
);
    import ssm_pkg::*;

    t_cfg                cfg;
    t_result             res;
    logic                advance;
    logic                s1_open;
    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    t_result             r_res;

    assign advance    = !r_out_valid || !i_out_stall;
    assign s1_open    = !r_s1_valid || advance;
    assign o_in_stall = !s1_open;
    assign o_cfg_ready = 1'b1;

    ssm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ssm_tick u_tick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_s1_valid && advance),
        .i_sample (r_sample),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_open) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_open && i_in_valid) begin
            r_sample <= i_proximity_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_duty_level     = r_res.duty;
    assign o_duty_written   = r_res.written;
    assign o_motor_mode     = r_res.mode;
    assign o_object_present = r_res.present;
    assign o_servo_angle    = r_res.present ? SERVO_ON_DEG : SERVO_OFF_DEG;

`ifndef SYNTHESIS
    a_written_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_duty_written) |->
        (r_res.mode == MODE_STARTING || r_res.mode == MODE_STOPPING))
        else $error("duty written outside a ramp");

    a_start_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_duty_written && r_res.mode == MODE_STARTING) |->
        (o_duty_level <= cfg.max_duty))
        else $error("start ramp passed max duty");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_s1_valid) |-> o_in_stall)
        else $error("input taken with both stages held");
`endif

endmodule
